>>> hdl/stmmc_pkg.sv
package stmmc_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam int CFG_W = 11;

endpackage

>>> hdl/sparse_table_min_modulo_chain.sv
// load: a beat is written into the table from idle, so loads can follow back to back
// build: per table entry, two reads of the level below (S_B0, S_B1) and a write (S_B2), set by
// the single read port of the table memory; query: per chain step, range-minimum reads (S_R0..S_R2),
// an element read (S_E0, S_E1) and the serial remainder unit (S_DIV); result is registered in S_DONE
// one command in flight; the next beat is taken once the block is back in idle
// arst_n clears control state and the built flag and sets element_count to 1024, not the table
module sparse_table_min_modulo_chain #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int TABLE_LEVELS = 11,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [stmmc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// element_index, element_value, query_value, left_index, right_index, 2 pad bits
	input  logic [95:0]                     s_tdata,
	// command
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// result_value
	output logic [31:0]                     m_tdata,
	// zero_divisor
	output logic                            m_tuser
);
	import stmmc_pkg::*;

	localparam int LVL_CAP = (2 ** TABLE_LEVELS) - 1;
	localparam int CAP_N = (MAX_ELEMENTS < LVL_CAP) ? MAX_ELEMENTS : LVL_CAP;
	localparam int CW = $clog2(CAP_N + 1);
	localparam int LW = (TABLE_LEVELS > 1) ? $clog2(TABLE_LEVELS) : 1;
	localparam int DEPTH = TABLE_LEVELS * MAX_ELEMENTS;
	localparam int AW = $clog2(DEPTH);
	localparam int VW = VALUE_WIDTH;
	localparam int DCW = $clog2(VW + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_B0, S_B1, S_B2, S_R0, S_R1, S_R2, S_E0, S_E1, S_DIV, S_DONE
	} state_t;

	function automatic logic [LW-1:0] flog2(input logic [CW-1:0] x);
		logic [LW-1:0] k;
		k = '0;
		for (int i = 0; i < CW; i++) begin
			if (x[i]) k = LW'(i);
		end
		return k;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] lvl, input logic [CW-1:0] pos);
		return AW'(lvl) * AW'(MAX_ELEMENTS) + AW'(pos);
	endfunction

	logic [VW-1:0] mem [DEPTH];
	logic [VW-1:0] rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic [VW-1:0] wdata;
	logic          we;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          built_q;
	logic [LW-1:0] lvl_q;
	logic [CW-1:0] i_q, hi_q, a_q, b_q, ra_q, rb_q;
	logic          search_q, flag_q;
	logic [VW-1:0] v_q, x_q, e_q, rem_q, sh_q;
	logic [DCW-1:0] dcnt_q;
	logic          m_tvalid_q;
	logic [31:0]   m_data_q;
	logic          m_flag_q;

	logic [CW-1:0] n_eff;
	logic [LW-1:0] top;
	logic [CW:0]   blk;
	logic [CW-1:0] rlen;
	logic [LW-1:0] rk;
	logic [CW-1:0] rpos_b;
	logic [VW-1:0] rmin, bmin;
	logic [VW:0]   dtry;
	logic [VW-1:0] drem;
	logic [CW:0]   a_inc;
	cmd_t          cmd;
	logic [VW-1:0] in_qv, in_ev;
	logic [31:0]   in_lo32, in_hi32, hi_cl32, n32;

	assign cmd = cmd_t'(s_tuser);
	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_data_q;
	assign m_tuser = m_flag_q;

	always_comb begin
		n32 = 32'(cnt_q);
		if (n32 < 32'd1) n32 = 32'd1;
		if (n32 > 32'(CAP_N)) n32 = 32'(CAP_N);
		n_eff = CW'(n32);
	end

	assign top = flog2(n_eff);
	assign blk = (CW + 1)'(1) << lvl_q;
	assign rlen = rb_q - ra_q + CW'(1);
	assign rk = flog2(rlen);
	assign rpos_b = CW'((CW + 1)'(rb_q) + (CW + 1)'(1) - ((CW + 1)'(1) << rk));
	assign rmin = (x_q < rdata_q) ? x_q : rdata_q;
	assign bmin = rmin;
	assign dtry = {rem_q, sh_q[VW-1]};
	assign drem = (dtry >= (VW + 1)'(e_q)) ? VW'(dtry - (VW + 1)'(e_q)) : dtry[VW-1:0];
	assign a_inc = (CW + 1)'(a_q) + (CW + 1)'(1);

	assign in_ev = VW'(s_tdata[41:10]);
	assign in_qv = VW'(s_tdata[73:42]);
	assign in_lo32 = 32'(s_tdata[83:74]);
	assign in_hi32 = 32'(s_tdata[93:84]);
	assign hi_cl32 = (in_hi32 > n32 - 32'd1) ? n32 - 32'd1 : in_hi32;

	always_comb begin
		raddr = '0;
		we = 1'b0;
		waddr = addr_of(lvl_q, i_q);
		wdata = bmin;
		case (state_q)
			S_B0: raddr = addr_of(lvl_q - LW'(1), i_q);
			S_B1: raddr = addr_of(lvl_q - LW'(1), CW'((CW + 1)'(i_q) + (blk >> 1)));
			S_B2: we = 1'b1;
			S_R0: raddr = addr_of(rk, ra_q);
			S_R1: raddr = addr_of(rk, rpos_b);
			S_E0: raddr = addr_of('0, a_q);
			default: raddr = '0;
		endcase
		if (state_q == S_IDLE && s_tvalid && cmd == CMD_LOAD) begin
			we = 32'(s_tdata[9:0]) < 32'(MAX_ELEMENTS);
			waddr = AW'(s_tdata[9:0]);
			wdata = in_ev;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic [CW-1:0] na, nb;
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= CW'(32'd1024 > 32'(CAP_N) ? CAP_N : 1024);
			built_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_data_q <= '0;
			m_flag_q <= 1'b0;
			lvl_q <= '0;
			i_q <= '0;
			hi_q <= '0;
			a_q <= '0;
			b_q <= '0;
			ra_q <= '0;
			rb_q <= '0;
			search_q <= 1'b0;
			flag_q <= 1'b0;
			v_q <= '0;
			x_q <= '0;
			e_q <= '0;
			rem_q <= '0;
			sh_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_DONE) m_tvalid_q <= 1'b0;
			if (cfg_valid) begin
				cnt_q <= (32'(cfg_data) > 32'(CAP_N)) ? CW'(CAP_N) : CW'(cfg_data);
				built_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						case (cmd)
							CMD_LOAD: begin
								if (32'(s_tdata[9:0]) < 32'(MAX_ELEMENTS)) built_q <= 1'b0;
							end
							CMD_BUILD: begin
								lvl_q <= LW'(1);
								i_q <= '0;
								if (top == '0) built_q <= 1'b1;
								else state_q <= S_B0;
							end
							CMD_QUERY: begin
								v_q <= in_qv;
								flag_q <= 1'b0;
								hi_q <= CW'(hi_cl32);
								a_q <= CW'(in_lo32);
								b_q <= CW'(hi_cl32);
								ra_q <= CW'(in_lo32);
								rb_q <= CW'(hi_cl32);
								search_q <= 1'b0;
								if (!built_q || in_qv == '0 || in_lo32 > hi_cl32) state_q <= S_DONE;
								else state_q <= S_R0;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_B0: state_q <= S_B1;
				S_B1: begin
					x_q <= rdata_q;
					state_q <= S_B2;
				end
				S_B2: begin
					if ((CW + 1)'(i_q) + (CW + 1)'(1) + blk <= (CW + 1)'(n_eff)) begin
						i_q <= i_q + CW'(1);
						state_q <= S_B0;
					end else if (lvl_q == top) begin
						built_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						lvl_q <= lvl_q + LW'(1);
						i_q <= '0;
						state_q <= S_B0;
					end
				end
				S_R0: state_q <= S_R1;
				S_R1: begin
					x_q <= rdata_q;
					state_q <= S_R2;
				end
				S_R2: begin
					if (!search_q) begin
						if (rmin > v_q) begin
							state_q <= S_DONE;
						end else if (a_q < b_q) begin
							search_q <= 1'b1;
							ra_q <= a_q;
							rb_q <= CW'(((CW + 1)'(a_q) + (CW + 1)'(b_q)) >> 1);
							state_q <= S_R0;
						end else begin
							state_q <= S_E0;
						end
					end else begin
						na = a_q;
						nb = b_q;
						if (rmin <= v_q) nb = rb_q;
						else na = rb_q + CW'(1);
						a_q <= na;
						b_q <= nb;
						if (na < nb) begin
							ra_q <= na;
							rb_q <= CW'(((CW + 1)'(na) + (CW + 1)'(nb)) >> 1);
							state_q <= S_R0;
						end else begin
							state_q <= S_E0;
						end
					end
				end
				S_E0: state_q <= S_E1;
				S_E1: begin
					if (rdata_q == '0) begin
						flag_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						e_q <= rdata_q;
						rem_q <= '0;
						sh_q <= v_q;
						dcnt_q <= DCW'(VW);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= drem;
					sh_q <= sh_q << 1;
					dcnt_q <= dcnt_q - DCW'(1);
					if (dcnt_q == DCW'(1)) begin
						v_q <= drem;
						if (drem == '0 || a_inc > (CW + 1)'(hi_q)) begin
							state_q <= S_DONE;
						end else begin
							a_q <= CW'(a_inc);
							b_q <= hi_q;
							ra_q <= CW'(a_inc);
							rb_q <= hi_q;
							search_q <= 1'b0;
							state_q <= S_R0;
						end
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_data_q <= 32'(v_q);
						m_flag_q <= flag_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import stmmc_pkg::*;

	localparam int N_MAX = 1024;
	localparam int LEVELS = 11;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [31:0] value;
		logic        zero_div;
	} chain_result_t;

	class chain_scoreboard;
		logic [31:0]   rmq [LEVELS][N_MAX];
		bit            built;
		int unsigned   count_reg;
		chain_result_t pending_q [$];
		int            mismatches;

		function new();
			built = 0;
			count_reg = 1024;
			mismatches = 0;
		endfunction

		function int unsigned log2_floor(int unsigned x);
			int unsigned k;
			k = 0;
			while (x > 1) begin
				x = x >> 1;
				k++;
			end
			return k;
		endfunction

		function int unsigned n_eff();
			if (count_reg < 1) return 1;
			if (count_reg > N_MAX) return N_MAX;
			return count_reg;
		endfunction

		function logic [31:0] span_min(int unsigned lo, int unsigned hi);
			int unsigned k;
			logic [31:0] a, b;
			k = log2_floor(hi - lo + 1);
			a = rmq[k][lo];
			b = rmq[k][hi + 1 - (1 << k)];
			return (a < b) ? a : b;
		endfunction

		function void set_count(int unsigned v);
			count_reg = v;
			built = 0;
		endfunction

		function void fill_levels();
			int unsigned n, top, half;
			n = n_eff();
			top = log2_floor(n);
			for (int unsigned k = 1; k <= top; k++) begin
				half = 1 << (k - 1);
				for (int unsigned i = 0; i + (1 << k) <= n; i++)
					rmq[k][i] = (rmq[k-1][i] < rmq[k-1][i+half]) ?
						rmq[k-1][i] : rmq[k-1][i+half];
			end
			built = 1;
		endfunction

		function chain_result_t run_chain(logic [31:0] v, int unsigned lo, int unsigned hi);
			chain_result_t r;
			int unsigned a, b, mid, n;
			logic [31:0] e;
			r.zero_div = 0;
			if (built) begin
				n = n_eff();
				if (hi > n - 1) hi = n - 1;
				while (v != 0 && lo <= hi) begin
					a = lo;
					b = hi;
					if (span_min(a, b) > v) break;
					while (a < b) begin
						mid = (a + b) / 2;
						if (span_min(a, mid) <= v) b = mid;
						else a = mid + 1;
					end
					e = rmq[0][a];
					if (e == 0) begin
						r.zero_div = 1;
						break;
					end
					v = v % e;
					lo = a + 1;
				end
			end
			r.value = v;
			return r;
		endfunction

		function void note_input(cmd_t cmd, logic [95:0] d);
			case (cmd)
				CMD_LOAD: begin
					rmq[0][d[9:0]] = d[41:10];
					built = 0;
				end
				CMD_BUILD: fill_levels();
				CMD_QUERY: pending_q = {pending_q, run_chain(d[73:42], d[83:74], d[93:84])};
				default: ;
			endcase
		endfunction

		function void check_result(logic [31:0] value, logic zero_div);
			chain_result_t exp_r;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: value %h flag %b", value, zero_div);
				return;
			end
			exp_r = pending_q.pop_front();
			if (value !== exp_r.value || zero_div !== exp_r.zero_div) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected %h/%b, got %h/%b",
						exp_r.value, exp_r.zero_div, value, zero_div);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [10:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;

	chain_scoreboard sb = new();
	int     tx_idle;
	int     rx_idle;
	longint cycles;
	bit     loaded [N_MAX];

	sparse_table_min_modulo_chain dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		m_tready <= ($urandom_range(99) >= rx_idle);
	end

	function logic [95:0] pack_item(logic [9:0] idx, logic [31:0] ev, logic [31:0] qv,
		logic [9:0] l, logic [9:0] r);
		return {2'b00, r, l, qv, ev, idx};
	endfunction

	task send_beat(cmd_t cmd, logic [95:0] d);
		if ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			while ($urandom_range(99) < tx_idle)
				@(posedge clk);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_input(cmd, d);
	endtask

	task load_elem(int unsigned idx, logic [31:0] v);
		send_beat(CMD_LOAD, pack_item(10'(idx), v, $urandom, 10'($urandom), 10'($urandom)));
		loaded[idx] = 1;
	endtask

	task query(logic [31:0] v, int unsigned l, int unsigned r);
		send_beat(CMD_QUERY, pack_item(10'($urandom), $urandom, v, 10'(l), 10'(r)));
	endtask

	task wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task write_count(logic [10:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_count(v);
	endtask

	function logic [31:0] rand_elem();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 5) return 0;
		if (p < 45) return $urandom_range(1, 1000);
		if (p < 70) return $urandom_range(1, 65535);
		return $urandom;
	endfunction

	task random_items(int num, int unsigned n, int build_pct);
		int unsigned p;
		for (int i = 0; i < num; i++) begin
			p = $urandom_range(99);
			if (p < 8)
				load_elem($urandom_range(N_MAX - 1), rand_elem());
			else if (p < 8 + build_pct || !sb.built)
				send_beat(CMD_BUILD, 96'($urandom));
			else if (p < 13 + build_pct)
				send_beat(CMD_NONE, {$urandom, $urandom, $urandom});
			else if (p < 20 + build_pct)
				query($urandom_range(1, 5000), $urandom_range(N_MAX - 1), $urandom_range(N_MAX - 1));
			else
				query($urandom, $urandom_range(0, n + 1), $urandom_range(N_MAX - 1));
		end
		query($urandom, 0, N_MAX - 1);
	endtask

	task run_phase(logic [10:0] cfg, int num, int build_pct);
		int unsigned n;
		wait_drained();
		write_count(cfg);
		n = sb.n_eff();
		for (int i = 0; i < n; i++)
			if (!loaded[i]) load_elem(i, rand_elem());
		send_beat(CMD_BUILD, 96'($urandom));
		random_items(num, n, build_pct);
	endtask

	initial begin
		arst_n = 1'b0;
		cycles = 0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_NONE;
		m_tready = 1'b0;
		tx_idle = 29;
		rx_idle = 67;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the covered part of the array, then the corner cases
		write_count(11'd40);
		for (int i = 0; i < 40; i++)
			load_elem(i, rand_elem());
		query(32'hFFFF_FFFF, 0, 1023);
		send_beat(CMD_NONE, {96{1'b1}});
		send_beat(CMD_BUILD, '0);
		query(32'hFFFF_FFFF, 0, 1023);
		query(32'h0, 0, 1023);
		query(32'h1234_5678, 10, 3);
		query(32'hFFFF_FFFF, 1023, 1023);
		load_elem(1023, 32'hFFFF_FFFF);
		load_elem(0, 32'h0);
		load_elem(1, 32'd7);
		query(32'd100, 0, 1023);
		send_beat(CMD_BUILD, {96{1'b1}});
		query(32'hFFFF_FFFF, 0, 1023);
		query(32'hFFFF_FFFF, 1, 1023);
		query(32'hFFFF_FFFF, 36, 1023);
		load_elem(0, 32'd3);
		send_beat(CMD_BUILD, '0);
		query(32'd100, 0, 1);
		query(32'hFFFF_FFFF, 0, 1023);

		run_phase(11'd100, 60, 2);
		tx_idle = 67;
		rx_idle = 29;
		run_phase(11'd0, 20, 10);
		run_phase(11'd17, 40, 10);
		tx_idle = 0;
		rx_idle = 0;
		run_phase(11'd64, 30, 2);
		run_phase(11'($urandom_range(2, 40)), 30, 10);

		wait_drained();
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

>>> sim.f
hdl/stmmc_pkg.sv
hdl/sparse_table_min_modulo_chain.sv
tb/testbench.sv
